[rtl/core/tlps_pkg.sv]
// Shared types, register reset values and lookup tables for the traffic light
// phase sequencer. No dependencies; used by tlps_step and the top level.
package tlps_pkg;

    localparam int unsigned NumCfgRegs    = 7;
    localparam int unsigned CfgIndexWidth = 3;
    localparam int unsigned CfgDataWidth  = 8;
    localparam int unsigned ShortWidth    = 5;
    localparam int unsigned LongWidth     = 8;
    localparam int unsigned PhaseWidth    = 3;
    localparam int unsigned SegWidth      = 7;
    localparam int unsigned InDataWidth   = 8;
    localparam int unsigned OutDataWidth  = 40;

    // Patterns at or above this digit show a blank display.
    localparam int unsigned DisplayDigits = 20;

    typedef enum logic [CfgIndexWidth-1:0] {
        CFG_PHASE_ONE   = 3'd0,
        CFG_PHASE_TWO   = 3'd1,
        CFG_PHASE_THREE = 3'd2,
        CFG_PHASE_FOUR  = 3'd3,
        CFG_PHASE_FIVE  = 3'd4,
        CFG_PHASE_SIX   = 3'd5,
        CFG_PHASE_SEVEN = 3'd6
    } cfg_index_t;

    localparam logic [PhaseWidth-1:0] PHASE_ONE   = 3'd1;
    localparam logic [PhaseWidth-1:0] PHASE_THREE = 3'd3;
    localparam logic [PhaseWidth-1:0] PHASE_SEVEN = 3'd7;

    localparam logic [ShortWidth-1:0] RstPhaseOne   = 5'd8;
    localparam logic [ShortWidth-1:0] RstPhaseTwo   = 5'd19;
    localparam logic [ShortWidth-1:0] RstPhaseThree = 5'd3;
    localparam logic [LongWidth-1:0]  RstPhaseFour  = 8'd12;
    localparam logic [LongWidth-1:0]  RstPhaseFive  = 8'd3;
    localparam logic [LongWidth-1:0]  RstPhaseSix   = 8'd12;
    localparam logic [LongWidth-1:0]  RstPhaseSeven = 8'd3;

    typedef struct packed {
        logic [ShortWidth-1:0] phase_one;
        logic [ShortWidth-1:0] phase_two;
        logic [ShortWidth-1:0] phase_three;
        logic [LongWidth-1:0]  phase_four;
        logic [LongWidth-1:0]  phase_five;
        logic [LongWidth-1:0]  phase_six;
        logic [LongWidth-1:0]  phase_seven;
    } cfg_t;

    typedef struct packed {
        logic [PhaseWidth-1:0] phase;
        logic [LongWidth-1:0]  remaining;
        logic                  request;
        logic                  walking;
        logic [SegWidth-1:0]   pattern;
    } seq_state_t;

    typedef struct packed {
        logic [3:0]            sig1_lamps;
        logic [3:0]            sig2_lamps;
        logic [2:0]            sig3_lamps;
        logic [2:0]            sig4_lamps;
    } lamps_t;

    // Phase length in ticks; a zero register counts as one.
    function automatic logic [LongWidth-1:0] duration_of(
        input logic [PhaseWidth-1:0] phase,
        input cfg_t                  cfg
    );
        logic [LongWidth-1:0] d;
        case (phase)
            3'd1:    d = {3'b000, cfg.phase_one};
            3'd2:    d = {3'b000, cfg.phase_two};
            3'd3:    d = {3'b000, cfg.phase_three};
            3'd4:    d = cfg.phase_four;
            3'd5:    d = cfg.phase_five;
            3'd6:    d = cfg.phase_six;
            3'd7:    d = cfg.phase_seven;
            default: d = 8'd1;
        endcase
        return (d == 8'd0) ? 8'd1 : d;
    endfunction

    function automatic logic [SegWidth-1:0] pattern_of(input logic [ShortWidth-1:0] digit);
        logic [SegWidth-1:0] p;
        case (digit)
            5'd0:    p = 7'h3F;
            5'd1:    p = 7'h06;
            5'd2:    p = 7'h5B;
            5'd3:    p = 7'h4F;
            5'd4:    p = 7'h66;
            5'd5:    p = 7'h6D;
            5'd6:    p = 7'h7D;
            5'd7:    p = 7'h07;
            5'd8:    p = 7'h7F;
            5'd9:    p = 7'h6F;
            5'd10:   p = 7'h77;
            5'd11:   p = 7'h7C;
            5'd12:   p = 7'h39;
            5'd13:   p = 7'h5E;
            5'd14:   p = 7'h79;
            5'd15:   p = 7'h71;
            5'd16:   p = 7'h3D;
            5'd17:   p = 7'h76;
            5'd18:   p = 7'h10;
            5'd19:   p = 7'h38;
            default: p = 7'h00;
        endcase
        if (32'(digit) >= DisplayDigits)
        begin
            p = 7'h00;
        end
        return p;
    endfunction

    function automatic lamps_t lamps_of(input logic [PhaseWidth-1:0] phase);
        lamps_t l;
        case (phase)
            3'd1:    l = '{4'h5, 4'h5, 3'd1, 3'd1};
            3'd2:    l = '{4'h8, 4'h8, 3'd1, 3'd1};
            3'd3:    l = '{4'h2, 4'h2, 3'd1, 3'd1};
            3'd4:    l = '{4'h1, 4'h1, 3'd4, 3'd1};
            3'd5:    l = '{4'h1, 4'h1, 3'd2, 3'd1};
            3'd6:    l = '{4'h1, 4'h1, 3'd1, 3'd4};
            3'd7:    l = '{4'h1, 4'h1, 3'd1, 3'd2};
            default: l = '{4'h1, 4'h1, 3'd1, 3'd1};
        endcase
        return l;
    endfunction

endpackage

[rtl/core/tlps_step.sv]
// Next-state logic of the phase sequencer: one item in, updated state out.
// Depends on tlps_pkg for the state and register structs and the tables.
module tlps_step (
    input  tlps_pkg::seq_state_t cur,
    input  tlps_pkg::cfg_t       cfg,
    input  logic                 second_tick,
    input  logic                 ped_press,
    output tlps_pkg::seq_state_t nxt,
    output tlps_pkg::lamps_t     lamps
);
    import tlps_pkg::*;

    logic [LongWidth-1:0]  rem_dec;
    logic [PhaseWidth-1:0] phase_adv;
    logic [LongWidth-1:0]  dur_adv;
    logic [ShortWidth-1:0] walk_digit;
    logic [ShortWidth-1:0] count_digit;
    logic [PhaseWidth-1:0] lamp_phase;

    assign rem_dec     = (cur.remaining != 8'd0) ? cur.remaining - 8'd1 : 8'd0;
    assign phase_adv   = (cur.phase >= PHASE_SEVEN) ? PHASE_ONE : cur.phase + 3'd1;
    assign dur_adv     = duration_of(phase_adv, cfg);
    assign walk_digit  = dur_adv[ShortWidth-1:0];
    assign count_digit = 5'(rem_dec - 8'd1);

    always_comb
    begin
        nxt = cur;
        // latch the press first so a same-tick phase entry sees it
        if (ped_press)
        begin
            nxt.request = 1'b1;
        end
        if (second_tick)
        begin
            nxt.remaining = rem_dec;
            if (cur.walking)
            begin
                if (rem_dec == 8'd0)
                begin
                    nxt.walking   = 1'b0;
                    nxt.request   = 1'b0;
                    nxt.remaining = duration_of(cur.phase, cfg);
                end
                else
                begin
                    nxt.pattern = pattern_of(count_digit);
                end
            end
            else if (rem_dec == 8'd0)
            begin
                nxt.phase = phase_adv;
                if (phase_adv <= PHASE_THREE && nxt.request)
                begin
                    nxt.walking   = 1'b1;
                    nxt.remaining = {3'b000, walk_digit} + 8'd1;
                    nxt.pattern   = pattern_of(walk_digit);
                end
                else
                begin
                    nxt.remaining = dur_adv;
                end
            end
        end
    end

    // hold the previous phase's lamps during a walk
    assign lamp_phase = !nxt.walking ? nxt.phase
                      : (nxt.phase <= PHASE_ONE) ? PHASE_SEVEN : nxt.phase - 3'd1;
    assign lamps = lamps_of(lamp_phase);

endmodule

[rtl/core/traffic_light_phase_sequencer_top.sv]
// Top level of the traffic light phase sequencer: stream ports, phase length
// registers, sequencer state and the result register. Uses tlps_pkg, tlps_step.

// One item per clock while m_tready holds: each accepted item (a second tick, a
// button press or both) updates the sequencer state and loads one result into
// the output register; a new item is taken in the same cycle that the held
// result is taken, so only m_tready stalls the single result register. Phase
// lengths are written through cfg_we/cfg_index/cfg_data by the user only while
// no item is in flight, which the block does not enforce; a new length takes
// effect the next time that phase or its walk interval starts. A walk of
// (phase length + 1) ticks runs before phases 1 to 3 when a press is pending.
module traffic_light_phase_sequencer_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // second_tick [0], ped_press [1], zero fill [7:2]
    input  logic [tlps_pkg::InDataWidth-1:0]    s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // sig1_lamps [3:0], sig2_lamps [7:4], sig3_lamps [10:8], sig4_lamps [13:11],
    // segments [20:14], phase_number [23:21], walk_active [24],
    // seconds_left [32:25], request_pending [33], zero fill [39:34]
    output logic [tlps_pkg::OutDataWidth-1:0]   m_tdata,
    input  logic                                cfg_we,
    input  logic [tlps_pkg::CfgIndexWidth-1:0]  cfg_index,
    input  logic [tlps_pkg::CfgDataWidth-1:0]   cfg_data
);
    import tlps_pkg::*;

    cfg_t                    cfg_reg;
    seq_state_t              state_reg;
    seq_state_t              state_next;
    lamps_t                  lamps;
    logic                    m_tvalid_reg;
    logic [OutDataWidth-1:0] m_tdata_reg;
    logic [OutDataWidth-1:0] m_tdata_next;
    logic                    accept;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{RstPhaseOne, RstPhaseTwo, RstPhaseThree,
                         RstPhaseFour, RstPhaseFive, RstPhaseSix, RstPhaseSeven};
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PHASE_ONE:   cfg_reg.phase_one   <= cfg_data[ShortWidth-1:0];
                CFG_PHASE_TWO:   cfg_reg.phase_two   <= cfg_data[ShortWidth-1:0];
                CFG_PHASE_THREE: cfg_reg.phase_three <= cfg_data[ShortWidth-1:0];
                CFG_PHASE_FOUR:  cfg_reg.phase_four  <= cfg_data;
                CFG_PHASE_FIVE:  cfg_reg.phase_five  <= cfg_data;
                CFG_PHASE_SIX:   cfg_reg.phase_six   <= cfg_data;
                CFG_PHASE_SEVEN: cfg_reg.phase_seven <= cfg_data;
                default:         ;
            endcase
        end
    end

    tlps_step u_step (
        .cur         (state_reg),
        .cfg         (cfg_reg),
        .second_tick (s_tdata[0]),
        .ped_press   (s_tdata[1]),
        .nxt         (state_next),
        .lamps       (lamps)
    );

    assign m_tdata_next = {6'b000000,
                           state_next.request,
                           state_next.remaining,
                           state_next.walking,
                           state_next.phase,
                           state_next.pattern,
                           lamps.sig4_lamps,
                           lamps.sig3_lamps,
                           lamps.sig2_lamps,
                           lamps.sig1_lamps};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= '{PHASE_ONE, {3'b000, RstPhaseOne}, 1'b0, 1'b0, 7'h00};
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg    <= state_next;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload holds while the result waits
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

endmodule
